### src/spq_pkg.sv
`timescale 1ns / 1ps
// spq_pkg: shared types, codes and the priority relation for the sorted priority queue
// used by spq_cell, spq_ctrl and sorted_priority_queue_unit; no dependencies
package spq_pkg;

    localparam int DATA_W = 32;
    localparam int QUEUE_DEPTH_DEFAULT = 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic [1:0] MODE_GE = 2'd0;
    localparam logic [1:0] MODE_GT = 2'd1;
    localparam logic [1:0] MODE_LE = 2'd2;
    localparam logic [1:0] MODE_LT = 2'd3;

    // one stored pair
    typedef struct packed {
        logic              occ;
        logic [DATA_W-1:0] val;
        logic [DATA_W-1:0] pri;
    } entry_t;

    // item travelling down the chain during an insert
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [DATA_W-1:0] val;
        logic [DATA_W-1:0] pri;
    } tok_t;

    // control shared by all cells
    typedef struct packed {
        logic [1:0] mode;
        logic       pop;
    } cell_ctrl_t;

    function automatic logic keeps_scanning(
        input logic [1:0]        mode,
        input logic [DATA_W-1:0] stored,
        input logic [DATA_W-1:0] fresh
    );
        logic result;
        case (mode)
            MODE_GE: result = ($signed(stored) >= $signed(fresh));
            MODE_GT: result = ($signed(stored) >  $signed(fresh));
            MODE_LE: result = ($signed(stored) <= $signed(fresh));
            MODE_LT: result = ($signed(stored) <  $signed(fresh));
            default: result = 1'b0;
        endcase
        return result;
    endfunction

endpackage

### src/spq_cell.sv
`timescale 1ns / 1ps
// spq_cell: one slot of the sorted chain, holds an entry and the insert item passing through
// depends on spq_pkg
module spq_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  spq_pkg::tok_t      tok_in,
    input  spq_pkg::entry_t    right_in,
    output spq_pkg::tok_t      tok_out,
    output spq_pkg::entry_t    entry_out
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;
    spq_pkg::tok_t   tok_reg;
    logic            keep;

    assign keep = entry_reg.occ && !tok_reg.found &&
                  spq_pkg::keeps_scanning(ctrl.mode, entry_reg.pri, tok_reg.pri);

    always_comb begin
        entry_next    = entry_reg;
        tok_out       = tok_reg;
        tok_out.valid = 1'b0;
        if (tok_reg.valid) begin
            if (!entry_reg.occ) begin
                // empty slot absorbs the item
                entry_next.occ = 1'b1;
                entry_next.val = tok_reg.val;
                entry_next.pri = tok_reg.pri;
            end else if (keep) begin
                tok_out = tok_reg;
            end else begin
                // take the item, push the old entry on
                entry_next.occ = 1'b1;
                entry_next.val = tok_reg.val;
                entry_next.pri = tok_reg.pri;
                tok_out.valid  = 1'b1;
                tok_out.found  = 1'b1;
                tok_out.val    = entry_reg.val;
                tok_out.pri    = entry_reg.pri;
            end
        end else if (ctrl.pop) begin
            entry_next = right_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.occ <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else begin
            entry_reg <= entry_next;
            tok_reg   <= tok_in;
        end
    end

    assign entry_out = entry_reg;

endmodule

### src/spq_ctrl.sv
`timescale 1ns / 1ps
// spq_ctrl: handshake, entry count, insert walk timing, mode register and result register
// depends on spq_pkg
module spq_ctrl #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_op,
    input  logic [spq_pkg::DATA_W-1:0] s_item_value,
    input  logic [spq_pkg::DATA_W-1:0] s_item_priority,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [spq_pkg::DATA_W-1:0] m_head_value,
    output logic [spq_pkg::DATA_W-1:0] m_head_priority,
    output logic [1:0]                 m_status,
    output logic                       m_is_empty,
    input  spq_pkg::entry_t            head,
    output spq_pkg::tok_t              inject,
    output spq_pkg::cell_ctrl_t        ctrl
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {ST_IDLE, ST_WALK} state_t;

    state_t                     state_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [CNT_W-1:0]           remain_reg;
    logic [1:0]                 mode_reg;
    logic                       m_valid_reg;
    logic [spq_pkg::DATA_W-1:0] hv_reg;
    logic [spq_pkg::DATA_W-1:0] hp_reg;
    logic [1:0]                 status_reg;
    logic                       empty_reg;
    logic [spq_pkg::DATA_W-1:0] hv_next;
    logic [spq_pkg::DATA_W-1:0] hp_next;
    logic [1:0]                 status_next;
    logic                       accept;
    logic                       is_full;
    logic                       is_none;
    logic                       do_insert;
    logic                       do_pop;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign is_full = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_none = (count_reg == '0);

    always_comb begin
        count_next  = count_reg;
        hv_next     = '0;
        hp_next     = '0;
        status_next = spq_pkg::STATUS_OK;
        do_insert   = 1'b0;
        do_pop      = 1'b0;
        case (s_op)
            spq_pkg::OP_INSERT: begin
                if (is_full) begin
                    status_next = spq_pkg::STATUS_FULL;
                end else begin
                    do_insert  = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            spq_pkg::OP_POP, spq_pkg::OP_PEEK: begin
                if (is_none) begin
                    status_next = spq_pkg::STATUS_EMPTY;
                end else begin
                    hv_next = head.val;
                    hp_next = head.pri;
                    if (s_op == spq_pkg::OP_POP) begin
                        do_pop     = accept;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign inject.valid = do_insert;
    assign inject.found = 1'b0;
    assign inject.val   = s_item_value;
    assign inject.pri   = s_item_priority;
    assign ctrl.mode    = mode_reg;
    assign ctrl.pop     = do_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            remain_reg  <= '0;
            mode_reg    <= spq_pkg::MODE_GE;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (do_insert) begin
                        remain_reg <= count_reg;
                        state_reg  <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (remain_reg == '0) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        remain_reg <= remain_reg - CNT_W'(1);
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
                hv_reg      <= hv_next;
                hp_reg      <= hp_next;
                status_reg  <= status_next;
                empty_reg   <= (count_next == '0);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_head_value    = hv_reg;
    assign m_head_priority = hp_reg;
    assign m_status        = status_reg;
    assign m_is_empty      = empty_reg;

endmodule

### src/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// sorted_priority_queue_unit: pop, peek and other items need no walk; the result is
// registered and valid the cycle after acceptance. an insert walks the cell chain one
// cell per cycle, and s_ready stays low until the walk state has ended.
// throughput: one pop/peek per cycle while m_ready takes each result; no new item during an insert walk.
// reset clears the entry count, every cell's occupancy, the result valid flag and the mode register.
// depends on spq_pkg, spq_ctrl, spq_cell
module sorted_priority_queue_unit #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_op,
    input  logic [spq_pkg::DATA_W-1:0] s_item_value,
    input  logic [spq_pkg::DATA_W-1:0] s_item_priority,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [spq_pkg::DATA_W-1:0] m_head_value,
    output logic [spq_pkg::DATA_W-1:0] m_head_priority,
    output logic [1:0]                 m_status,
    output logic                       m_is_empty
);

    spq_pkg::tok_t       tok_link   [QUEUE_DEPTH+1];
    spq_pkg::entry_t     entry_link [QUEUE_DEPTH+1];
    spq_pkg::cell_ctrl_t cell_ctrl;

    spq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_item_value    (s_item_value),
        .s_item_priority (s_item_priority),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_head_value    (m_head_value),
        .m_head_priority (m_head_priority),
        .m_status        (m_status),
        .m_is_empty      (m_is_empty),
        .head            (entry_link[0]),
        .inject          (tok_link[0]),
        .ctrl            (cell_ctrl)
    );

    // past the last cell everything reads as empty
    assign entry_link[QUEUE_DEPTH] = '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        spq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cell_ctrl),
            .tok_in    (tok_link[i]),
            .right_in  (entry_link[i+1]),
            .tok_out   (tok_link[i+1]),
            .entry_out (entry_link[i])
        );
    end

endmodule
